// ===== hdl/blpcs_pkg.sv =====
// Shared types and constants for the button long-press command selector.
package blpcs_pkg;

    localparam int CFG_WIDTH           = 24;
    localparam int CFG_INDEX_WIDTH     = 8;
    localparam int TIMER_WIDTH_DEFAULT = 24;
    localparam int COUNT_WIDTH         = 3;
    localparam int CODE_WIDTH          = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLINK_HALF = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW     = CFG_INDEX_WIDTH'(3);

    // Register values after reset.
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(100);
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(1000);
    localparam logic [CFG_WIDTH-1:0] BLINK_HALF_RESET = CFG_WIDTH'(500);
    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET     = CFG_WIDTH'(5000);

    // Press counter saturates here.
    localparam logic [COUNT_WIDTH-1:0] PRESS_MAX = COUNT_WIDTH'(7);

    // Command codes: idle, or a press count from one up to CMD_LAST.
    localparam logic [CODE_WIDTH-1:0] CMD_IDLE  = CODE_WIDTH'(0);
    localparam logic [CODE_WIDTH-1:0] CMD_FIRST = CODE_WIDTH'(1);
    localparam logic [CODE_WIDTH-1:0] CMD_LAST  = CODE_WIDTH'(5);

    typedef logic [CFG_WIDTH-1:0]       cfg_word_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [COUNT_WIDTH-1:0]     press_count_t;
    typedef logic [CODE_WIDTH-1:0]      cmd_code_t;

endpackage

// ===== hdl/blpcs_if.sv =====
// Valid/ready channel interfaces for button ticks, results and configuration writes.
interface blpcs_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface blpcs_out_if
    import blpcs_pkg::*;
;
    logic      valid;
    logic      ready;
    cmd_code_t command_code;
    logic      command_strobe;
    logic      bounce_led;
    logic      blink_indicator;
    logic      selecting;

    modport source (
        output valid, output command_code, output command_strobe,
        output bounce_led, output blink_indicator, output selecting, input ready
    );
    modport sink (
        input valid, input command_code, input command_strobe,
        input bounce_led, input blink_indicator, input selecting, output ready
    );
endinterface

interface blpcs_cfg_if
    import blpcs_pkg::*;
;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_word_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/button_long_press_command_selector.sv =====
// Top level: debounced button decoder with long press and multi-press command selection.
// The input register holds each accepted tick beat; the result register loads from it
// as soon as it is empty or being drained. Throughput: one tick beat per cycle while the
// result sink keeps ready high; the whole state update is one pass of logic between them.
// Reset (rst_n low, asynchronous): all decoder state clears, the command is idle,
// and the four timing registers return to 100, 1000, 500 and 5000 ticks.
module button_long_press_command_selector
    import blpcs_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    blpcs_cfg_if.sink   cfg,
    blpcs_in_if.sink    button,
    blpcs_out_if.source result
);

    // The limit compare runs at whichever is wider, the timer or the register.
    localparam int CMP_W = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
    localparam logic [CMP_W-1:0] TMASK = CMP_W'((65'd1 << TIMER_WIDTH) - 65'd1);

    typedef logic [TIMER_WIDTH-1:0] timer_t;

    // A timer has expired once its advanced count reaches its register value,
    // with the register clamped to the largest count the timer can hold. A
    // register of zero therefore expires on the first tick, just like one.
    function automatic logic expired(input timer_t cnt, input cfg_word_t lim);
        logic [CMP_W-1:0] cnt_ext;
        logic [CMP_W-1:0] lim_ext;
        logic [CMP_W-1:0] clamp;
        cnt_ext = CMP_W'(cnt);
        lim_ext = CMP_W'(lim);
        clamp   = (lim_ext > TMASK) ? TMASK : lim_ext;
        return cnt_ext >= clamp;
    endfunction

    // Timing registers.
    cfg_word_t debounce_reg;
    cfg_word_t long_press_reg;
    cfg_word_t blink_half_reg;
    cfg_word_t window_reg;

    // Input register.
    logic in_valid_reg;
    logic level_reg;

    // Decoder state.
    logic         prev_level_reg,    prev_level_next;
    logic         bounce_active_reg, bounce_active_next;
    logic         released_reg,      released_next;
    logic         long_active_reg,   long_active_next;
    logic         hold_timing_reg,   hold_timing_next;
    press_count_t press_count_reg,   press_count_next;
    timer_t       bounce_timer_reg,  bounce_timer_next;
    timer_t       hold_timer_reg,    hold_timer_next;
    timer_t       blink_timer_reg,   blink_timer_next;
    timer_t       window_timer_reg,  window_timer_next;
    logic         blink_state_reg,   blink_state_next;
    cmd_code_t    chosen_reg,        chosen_next;
    logic         strobe_next;

    // Result register.
    logic      out_valid_reg;
    cmd_code_t out_code_reg;
    logic      out_strobe_reg;
    logic      out_bounce_reg;
    logic      out_blink_reg;
    logic      out_selecting_reg;

    timer_t bounce_inc;
    timer_t hold_inc;
    timer_t blink_inc;
    timer_t window_inc;

    logic step_ok;
    logic step;

    // The result register takes a new beat when it is empty or being drained,
    // and the input register refills in the same cycle it hands its beat over.
    assign step_ok      = !out_valid_reg || result.ready;
    assign step         = in_valid_reg && step_ok;
    assign button.ready = !in_valid_reg || step_ok;
    assign cfg.ready    = 1'b1;

    assign result.valid           = out_valid_reg;
    assign result.command_code    = out_code_reg;
    assign result.command_strobe  = out_strobe_reg;
    assign result.bounce_led      = out_bounce_reg;
    assign result.blink_indicator = out_blink_reg;
    assign result.selecting       = out_selecting_reg;

    assign bounce_inc = bounce_timer_reg + TIMER_WIDTH'(1);
    assign hold_inc   = hold_timer_reg + TIMER_WIDTH'(1);
    assign blink_inc  = blink_timer_reg + TIMER_WIDTH'(1);
    assign window_inc = window_timer_reg + TIMER_WIDTH'(1);

    // Configuration writes. Indexes past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            blink_half_reg <= BLINK_HALF_RESET;
            window_reg     <= WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE:   debounce_reg   <= cfg.data;
                REG_LONG_PRESS: long_press_reg <= cfg.data;
                REG_BLINK_HALF: blink_half_reg <= cfg.data;
                REG_WINDOW:     window_reg     <= cfg.data;
                default:        ;
            endcase
        end
    end

    // One tick of the decoder. Timers that were running at the start of the
    // tick advance first, in the order debounce, hold, blink, window; the edge
    // is handled last, so it sees the flags that the expiries left behind.
    always_comb
    begin
        prev_level_next    = prev_level_reg;
        bounce_active_next = bounce_active_reg;
        released_next      = released_reg;
        long_active_next   = long_active_reg;
        hold_timing_next   = hold_timing_reg;
        press_count_next   = press_count_reg;
        bounce_timer_next  = bounce_timer_reg;
        hold_timer_next    = hold_timer_reg;
        blink_timer_next   = blink_timer_reg;
        window_timer_next  = window_timer_reg;
        blink_state_next   = blink_state_reg;
        chosen_next        = chosen_reg;
        strobe_next        = 1'b0;

        // End of debounce: a button still held starts long-press timing,
        // unless that timing is already running.
        if (bounce_active_reg)
        begin
            bounce_timer_next = bounce_inc;
            if (expired(bounce_inc, debounce_reg))
            begin
                bounce_active_next = 1'b0;
                bounce_timer_next  = '0;
                if (!released_reg && !hold_timing_reg)
                begin
                    hold_timing_next = 1'b1;
                    hold_timer_next  = '0;
                end
            end
        end

        // Long press reached: open the selection window if it is not open yet.
        if (hold_timing_reg)
        begin
            hold_timer_next = hold_inc;
            if (expired(hold_inc, long_press_reg))
            begin
                hold_timing_next = 1'b0;
                hold_timer_next  = '0;
                if (!long_active_reg)
                begin
                    long_active_next  = 1'b1;
                    blink_timer_next  = '0;
                    window_timer_next = '0;
                end
            end
        end

        // Selection window: blink toggles first, then the window may close.
        if (long_active_reg)
        begin
            blink_timer_next = blink_inc;
            if (expired(blink_inc, blink_half_reg))
            begin
                blink_timer_next = '0;
                blink_state_next = !blink_state_reg;
            end

            window_timer_next = window_inc;
            if (expired(window_inc, window_reg))
            begin
                window_timer_next = '0;
                if (press_count_reg >= CODE_WIDTH'(CMD_FIRST)
                    && press_count_reg <= CODE_WIDTH'(CMD_LAST))
                begin
                    chosen_next = cmd_code_t'(press_count_reg);
                end
                else
                begin
                    chosen_next = CMD_IDLE;
                end
                strobe_next      = 1'b1;
                press_count_next = '0;
                long_active_next = 1'b0;
            end
        end

        // Edge outside the debounce window.
        if (level_reg != prev_level_reg && !bounce_active_next)
        begin
            if (level_reg)
            begin
                released_next = 1'b0;
                if (long_active_next && press_count_next < PRESS_MAX)
                begin
                    press_count_next = press_count_next + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                // A release before the window opens abandons the long press.
                released_next = 1'b1;
                if (!long_active_next)
                begin
                    hold_timing_next = 1'b0;
                    hold_timer_next  = '0;
                    press_count_next = '0;
                end
            end
            bounce_active_next = 1'b1;
            bounce_timer_next  = '0;
        end
        prev_level_next = level_reg;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (button.valid && button.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (button.valid && button.ready)
        begin
            level_reg <= button.button_level;
        end
    end

    // Decoder state advances once per tick beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg    <= 1'b0;
            bounce_active_reg <= 1'b0;
            released_reg      <= 1'b0;
            long_active_reg   <= 1'b0;
            hold_timing_reg   <= 1'b0;
            press_count_reg   <= '0;
            bounce_timer_reg  <= '0;
            hold_timer_reg    <= '0;
            blink_timer_reg   <= '0;
            window_timer_reg  <= '0;
            blink_state_reg   <= 1'b0;
            chosen_reg        <= CMD_IDLE;
        end
        else if (step)
        begin
            prev_level_reg    <= prev_level_next;
            bounce_active_reg <= bounce_active_next;
            released_reg      <= released_next;
            long_active_reg   <= long_active_next;
            hold_timing_reg   <= hold_timing_next;
            press_count_reg   <= press_count_next;
            bounce_timer_reg  <= bounce_timer_next;
            hold_timer_reg    <= hold_timer_next;
            blink_timer_reg   <= blink_timer_next;
            window_timer_reg  <= window_timer_next;
            blink_state_reg   <= blink_state_next;
            chosen_reg        <= chosen_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_code_reg      <= chosen_next;
            out_strobe_reg    <= strobe_next;
            out_bounce_reg    <= bounce_active_next;
            out_blink_reg     <= blink_state_next;
            out_selecting_reg <= long_active_next;
        end
    end

    // Presses are only counted while the selection window is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        press_count_reg != '0 |-> long_active_reg)
        else $error("press count held outside the selection window");

    // Idle debounce and hold timers always sit at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        bounce_timer_reg != '0 |-> bounce_active_reg)
        else $error("debounce timer counting while debounce is idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        hold_timer_reg != '0 |-> hold_timing_reg)
        else $error("hold timer counting while long-press timing is idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        window_timer_reg != '0 |-> long_active_reg)
        else $error("window timer counting while selection is closed");

    // A strobe beat closes the window, so it can never report selecting.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_strobe_reg |-> !out_selecting_reg)
        else $error("strobe issued while the selection window stays open");

    // The chosen command is idle or a valid press-count code.
    assert property (@(posedge clk) disable iff (!rst_n)
        chosen_reg <= CMD_LAST)
        else $error("chosen command out of range");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the button long-press command selector.
module tb
    import blpcs_pkg::*;
;

    localparam int TW             = TIMER_WIDTH_DEFAULT;
    localparam int RANDOM_TICKS   = 600;
    // The last stretch of random ticks runs with no gaps and no new sink stalls.
    localparam int CALM_TAIL      = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // An index that no register decodes; writes to it must change nothing.
    localparam cfg_index_t REG_ABSENT = '1;
    localparam cfg_word_t  WORD_MAX   = '1;

    typedef logic [TW-1:0] tick_count_t;

    // One result beat, field for field as the result channel carries it.
    typedef struct packed {
        cmd_code_t command_code;
        logic      command_strobe;
        logic      bounce_led;
        logic      blink_indicator;
        logic      selecting;
    } decoder_out_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    // One step of the directed part: either a tick beat or a register write.
    // Where the outcome is obvious, the expected beat is typed in the row.
    typedef struct {
        row_kind_t    kind;
        logic         level;
        cfg_index_t   index;
        cfg_word_t    data;
        bit           known;
        decoder_out_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    blpcs_in_if  button_ch ();
    blpcs_out_if result_ch ();
    blpcs_cfg_if cfg_ch ();

    button_long_press_command_selector DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .button (button_ch),
        .result (result_ch)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder state as the testbench tracks it. It is advanced once per
    // accepted tick beat, so the stimulus can look at it to decide what
    // the button should do next (hold until selection opens, and so on).
    // ------------------------------------------------------------------
    cfg_word_t    set_debounce, set_long_press, set_blink_half, set_window;
    logic         dec_prev_level, dec_bouncing, dec_released, dec_selecting, dec_holding;
    logic         dec_blink;
    press_count_t dec_presses;
    cmd_code_t    dec_command;
    tick_count_t  dec_bounce_cnt, dec_hold_cnt, dec_blink_cnt, dec_window_cnt;

    decoder_out_t pending_outputs[$];
    int           error_count;
    int           ticks_sent;
    int           beats_checked;

    // Idling controls, changed by the stimulus from phase to phase.
    bit           calm;
    int           calm_from;
    int unsigned  src_gap_pct;
    int unsigned  sink_stall_pct;
    int unsigned  sink_stall_left;

    // Advances one timer by a tick. The limit is clamped to what the counter
    // can hold; a limit of zero therefore expires on the first tick, as one does.
    function automatic bit timer_step(inout tick_count_t cnt, input cfg_word_t setting);
        longint unsigned top;
        longint unsigned lim;
        top = (longint'(1) << TW) - 1;
        lim = (longint'(setting) > top) ? top : longint'(setting);
        cnt = cnt + 1'b1;
        return longint'(cnt) >= lim;
    endfunction

    // Works out the result beat of one tick and moves the tracked state on.
    // Timers running at the start of the tick go first (debounce, hold,
    // blink, window), the button edge is handled last.
    function automatic decoder_out_t decode_tick(logic level);
        logic         was_bouncing;
        logic         was_holding;
        logic         was_selecting;
        decoder_out_t r;
        was_bouncing  = dec_bouncing;
        was_holding   = dec_holding;
        was_selecting = dec_selecting;
        r = '0;

        if (was_bouncing && timer_step(dec_bounce_cnt, set_debounce)) begin
            dec_bouncing   = 1'b0;
            dec_bounce_cnt = '0;
            // Still held when the debounce window ends: long-press timing starts,
            // unless it is already running, in which case it keeps its count.
            if (!dec_released && !dec_holding) begin
                dec_holding  = 1'b1;
                dec_hold_cnt = '0;
            end
        end

        if (was_holding && dec_holding && timer_step(dec_hold_cnt, set_long_press)) begin
            dec_holding  = 1'b0;
            dec_hold_cnt = '0;
            // A second long press while selecting leaves the window as it is.
            if (!dec_selecting) begin
                dec_selecting  = 1'b1;
                dec_blink_cnt  = '0;
                dec_window_cnt = '0;
            end
        end

        // The blink toggle comes before the window close on a shared tick.
        if (was_selecting && dec_selecting && timer_step(dec_blink_cnt, set_blink_half)) begin
            dec_blink_cnt = '0;
            dec_blink     = ~dec_blink;
        end

        if (was_selecting && dec_selecting && timer_step(dec_window_cnt, set_window)) begin
            dec_window_cnt = '0;
            dec_command    = (dec_presses >= CMD_FIRST && dec_presses <= CMD_LAST) ?
                             cmd_code_t'(dec_presses) : CMD_IDLE;
            r.command_strobe = 1'b1;
            dec_presses      = '0;
            dec_selecting    = 1'b0;
        end

        if (level != dec_prev_level && !dec_bouncing) begin
            if (level) begin
                dec_released = 1'b0;
                if (dec_selecting && dec_presses < PRESS_MAX)
                    dec_presses = dec_presses + 1'b1;
            end
            else begin
                dec_released = 1'b1;
                // A release outside selection cancels long-press timing.
                if (!dec_selecting) begin
                    dec_holding  = 1'b0;
                    dec_hold_cnt = '0;
                    dec_presses  = '0;
                end
            end
            dec_bouncing   = 1'b1;
            dec_bounce_cnt = '0;
        end
        dec_prev_level = level;

        r.command_code    = dec_command;
        r.bounce_led      = dec_bouncing;
        r.blink_indicator = dec_blink;
        r.selecting       = dec_selecting;
        return r;
    endfunction

    function automatic void apply_register(cfg_index_t idx, cfg_word_t val);
        case (idx)
            REG_DEBOUNCE:   set_debounce   = val;
            REG_LONG_PRESS: set_long_press = val;
            REG_BLINK_HALF: set_blink_half = val;
            REG_WINDOW:     set_window     = val;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("MISMATCH beat %0d %s: expected %0d, got %0d", beats_checked, what, want, got);
        error_count++;
    endtask

    // Drives one tick beat, optionally after a gap, and waits for it to be
    // taken. The expected beat is queued at the edge that accepts the tick.
    task automatic send_tick(input logic level, input bit known = 1'b0,
                             input decoder_out_t want = '0);
        decoder_out_t predicted;
        int           gap;
        if (ticks_sent >= calm_from)
            calm = 1'b1;
        if (!calm && src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            button_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        button_ch.valid        <= 1'b1;
        button_ch.button_level <= level;
        do @(posedge clk); while (!button_ch.ready);
        predicted = decode_tick(level);
        pending_outputs.push_back(known ? want : predicted);
        ticks_sent++;
    endtask

    // Register writes happen only once every expected beat has come back.
    // Every tick yields a beat, so an empty queue means the block is idle.
    task automatic write_register(cfg_index_t idx, cfg_word_t val);
        @(negedge clk);
        button_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_register(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic hold_level(logic level, int n);
        repeat (n) send_tick(level);
    endtask

    // A hold long enough to get through the debounce window, where the
    // window is short enough for that to make sense.
    function automatic int press_span();
        int d;
        d = (set_debounce > 6) ? 6 : int'(set_debounce);
        return d + 1 + $urandom_range(0, 3);
    endfunction

    // Mostly small values so the timers expire often; now and then zero,
    // the largest value, or a fully random word.
    function automatic cfg_word_t pick_setting(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return WORD_MAX;
            2:       return cfg_word_t'($urandom);
            default: return cfg_word_t'($urandom_range(lo, hi));
        endcase
    endfunction

    // A well-formed command: press and hold until selection opens, release,
    // then a number of short presses and wait for the window to close.
    // The guards keep a phase bounded when a register holds a huge value.
    task automatic command_sequence(int presses);
        int guard;
        send_tick(1'b1);
        // Contact bounce while the debounce window is still open.
        repeat ($urandom_range(0, 3)) send_tick(logic'($urandom_range(0, 1)));
        guard = 0;
        while (!dec_selecting && guard < 80) begin
            send_tick(1'b1);
            guard++;
        end
        hold_level(1'b0, press_span());
        repeat (presses) begin
            hold_level(1'b1, press_span());
            hold_level(1'b0, press_span());
        end
        guard = 0;
        while (dec_selecting && guard < 150) begin
            send_tick($urandom_range(0, 9) == 0);
            guard++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: ready is dropped in random bursts at a rate set per phase,
    // and no new burst starts during the calm tail.
    // ------------------------------------------------------------------
    initial begin
        result_ch.ready = 1'b0;
        sink_stall_left = 0;
        forever begin
            @(negedge clk);
            if (sink_stall_left > 0) begin
                result_ch.ready <= 1'b0;
                sink_stall_left--;
            end
            else if (!calm && sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                result_ch.ready <= 1'b0;
                sink_stall_left = $urandom_range(1, 19) - 1;
            end
            else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted result beat is checked against the oldest expectation.
    always @(posedge clk) begin : check_results
        decoder_out_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("result beat with nothing expected, command_code", -1,
                                int'(result_ch.command_code));
            end
            else begin
                want = pending_outputs.pop_front();
                if (result_ch.command_code !== want.command_code)
                    report_mismatch("command_code", int'(want.command_code),
                                    int'(result_ch.command_code));
                if (result_ch.command_strobe !== want.command_strobe)
                    report_mismatch("command_strobe", int'(want.command_strobe),
                                    int'(result_ch.command_strobe));
                if (result_ch.bounce_led !== want.bounce_led)
                    report_mismatch("bounce_led", int'(want.bounce_led),
                                    int'(result_ch.bounce_led));
                if (result_ch.blink_indicator !== want.blink_indicator)
                    report_mismatch("blink_indicator", int'(want.blink_indicator),
                                    int'(result_ch.blink_indicator));
                if (result_ch.selecting !== want.selecting)
                    report_mismatch("selecting", int'(want.selecting),
                                    int'(result_ch.selecting));
            end
            beats_checked++;
        end
    end

    // Watchdog: too long without a beat on any channel means the block hung.
    always @(posedge clk) begin : watchdog
        int quiet_cycles;
        if ((button_ch.valid && button_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT after %0d cycles with no beat", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    stim_row_t directed_rows[$];

    function automatic void add_tick_row(logic level);
        directed_rows.push_back('{ROW_TICK, level, '0, '0, 1'b0, '0});
    endfunction

    function automatic void add_known_row(logic level, decoder_out_t want);
        directed_rows.push_back('{ROW_TICK, level, '0, '0, 1'b1, want});
    endfunction

    function automatic void add_write_row(cfg_index_t idx, cfg_word_t val);
        directed_rows.push_back('{ROW_WRITE, 1'b0, idx, val, 1'b0, '0});
    endfunction

    initial begin : stimulus
        int   kind;
        logic bit_level;
        rst_n                  = 1'b0;
        button_ch.valid        = 1'b0;
        button_ch.button_level = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_DEBOUNCE;
        cfg_ch.data            = '0;
        error_count    = 0;
        ticks_sent     = 0;
        beats_checked  = 0;
        calm           = 1'b0;
        src_gap_pct    = 10;
        sink_stall_pct = 10;

        // Tracked state after reset: registers at their reset values,
        // everything else cleared and the command idle.
        set_debounce   = DEBOUNCE_RESET;
        set_long_press = LONG_PRESS_RESET;
        set_blink_half = BLINK_HALF_RESET;
        set_window     = WINDOW_RESET;
        dec_prev_level = 1'b0;
        dec_bouncing   = 1'b0;
        dec_released   = 1'b0;
        dec_selecting  = 1'b0;
        dec_holding    = 1'b0;
        dec_blink      = 1'b0;
        dec_presses    = '0;
        dec_command    = CMD_IDLE;
        dec_bounce_cnt = '0;
        dec_hold_cnt   = '0;
        dec_blink_cnt  = '0;
        dec_window_cnt = '0;

        // Directed part, under the reset timing first. A released button does
        // nothing; a press lights the bounce LED, and edges inside the debounce
        // window are ignored.
        add_known_row(1'b0, '{CMD_IDLE, 1'b0, 1'b0, 1'b0, 1'b0});
        add_known_row(1'b1, '{CMD_IDLE, 1'b0, 1'b1, 1'b0, 1'b0});
        add_known_row(1'b0, '{CMD_IDLE, 1'b0, 1'b1, 1'b0, 1'b0});
        add_known_row(1'b1, '{CMD_IDLE, 1'b0, 1'b1, 1'b0, 1'b0});
        // All registers to zero. The debounce count is already past the new
        // limit, so it ends on the next tick; each zero acts like one, so hold,
        // selection, blink toggle and window close follow tick by tick, with
        // blink and window expiring together.
        add_write_row(REG_DEBOUNCE, '0);
        add_write_row(REG_LONG_PRESS, '0);
        add_write_row(REG_BLINK_HALF, '0);
        add_write_row(REG_WINDOW, '0);
        add_tick_row(1'b1);
        add_tick_row(1'b1);
        add_tick_row(1'b1);
        // A short window: release cancels nothing pending, a new long press
        // opens selection, and two counted presses become a command.
        add_write_row(REG_WINDOW, cfg_word_t'(6));
        add_write_row(REG_BLINK_HALF, cfg_word_t'(2));
        add_tick_row(1'b0);
        add_tick_row(1'b1);
        add_tick_row(1'b1);
        add_tick_row(1'b1);
        add_tick_row(1'b0);
        add_tick_row(1'b1);
        add_tick_row(1'b0);
        add_tick_row(1'b1);
        add_tick_row(1'b0);
        add_tick_row(1'b0);
        // Largest debounce value, then a write to an index nobody decodes.
        add_write_row(REG_DEBOUNCE, WORD_MAX);
        add_write_row(REG_ABSENT, cfg_word_t'(24'hA5A5A5));
        add_tick_row(1'b1);
        add_tick_row(1'b0);

        // From this many ticks on, no gaps, register writes or new sink stalls occur.
        calm_from = directed_rows.size() + RANDOM_TICKS - CALM_TAIL;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_register(directed_rows[i].index, directed_rows[i].data);
            else
                send_tick(directed_rows[i].level, directed_rows[i].known,
                          directed_rows[i].want);
        end

        // Random part: phases of new timing followed by a button sequence.
        // Most sequences are full long-press commands with random press
        // counts (zero up to past saturation); the rest are presses released
        // too early and plain noise.
        while (ticks_sent < directed_rows.size() + RANDOM_TICKS) begin
            case ($urandom_range(0, 2))
                0:       src_gap_pct = 0;
                1:       src_gap_pct = 5;
                default: src_gap_pct = 20;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_stall_pct = 0;
                1:       sink_stall_pct = 5;
                default: sink_stall_pct = 20;
            endcase

            if (!calm) begin
                if ($urandom_range(0, 1))
                    write_register(REG_DEBOUNCE, pick_setting(1, 4));
                if ($urandom_range(0, 1))
                    write_register(REG_LONG_PRESS, pick_setting(1, 12));
                if ($urandom_range(0, 1))
                    write_register(REG_BLINK_HALF, pick_setting(1, 6));
                if ($urandom_range(0, 1))
                    write_register(REG_WINDOW, pick_setting(10, 80));
                if ($urandom_range(0, 7) == 0)
                    write_register(cfg_index_t'($urandom_range(4, 255)),
                                   cfg_word_t'($urandom));
            end

            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                command_sequence($urandom_range(0, 8));
            end
            else if (kind < 17) begin
                hold_level(1'b1, $urandom_range(1, 8));
                hold_level(1'b0, $urandom_range(1, 8));
            end
            else begin
                repeat ($urandom_range(5, 30)) begin
                    bit_level = logic'($urandom_range(0, 1));
                    send_tick(bit_level);
                end
            end
        end

        // Drain: let every expected beat arrive, then wait out DRAIN_CYCLES so a
        // stray extra beat would still be caught.
        @(negedge clk);
        button_ch.valid <= 1'b0;
        calm = 1'b1;
        while (pending_outputs.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/blpcs_pkg.sv
hdl/blpcs_if.sv
hdl/button_long_press_command_selector.sv
dv/tb.sv
